/* hw/rtl/stps_pkg.sv */
package stps_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_CODE_LOW  = 3'd0;
  localparam logic [2:0] REG_CODE_HIGH = 3'd1;
  localparam logic [2:0] REG_CHUNK     = 3'd2;
  localparam logic [2:0] REG_OFFSET    = 3'd3;
  localparam logic [2:0] REG_SAMPLES   = 3'd4;
  localparam logic [2:0] REG_TESTS     = 3'd5;

  localparam logic [1:0] KIND_MOVE   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_STEP   = 2'd2;
  localparam logic [1:0] KIND_CODE   = 2'd3;

  localparam logic [7:0] SETTLE_SEEK  = 8'd25;
  localparam logic [7:0] SETTLE_LONG  = 8'd250;
  localparam logic [7:0] SETTLE_CREEP = 8'd100;
  localparam logic [7:0] SETTLE_FINAL = 8'd10;

  localparam logic [14:0] CNT_MAX = 15'h7fff;

  typedef enum logic [2:0] {
    EM_SEEK,
    EM_BACKOFF,
    EM_SAMPLE_BACK,
    EM_FINAL_BACK,
    EM_CREEP,
    EM_HOME,
    EM_POS,
    EM_CODE_REC
  } emit_sel_t;

  typedef struct packed {
    logic      latch_in;
    logic      emit;
    emit_sel_t sel;
    logic      header;
    logic      last;
    logic      inc_home;
    logic      add_backoff;
    logic      inc_creep;
    logic      clr_steps;
    logic      store;
    logic      inc_sample;
    logic      clr_sample;
    logic      clr_home;
    logic      clr_all;
    logic      inc_test;
    logic      idx_clr;
    logic      idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic contact;
    logic button;
    logic final_sample;
    logic idx_last;
    logic test_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/stepper_touch_probe_sequencer_top.sv */
// Stepper touch-probe sequencer.
// Input stream (s_*): one word per motor tick, carrying the start button level
// and the probe ADC code. Output stream (m_*): motor moves, then per test a
// header, step records and code records; m_tuser holds the kind, m_tlast marks
// the final result of a tick. APB port holds the six setup registers at 4*i.
// One word is handled at a time. A tick that gives no result or one result
// returns to taking input from S_EXEC; the final forward tick also passes
// through S_HOME for the home move. A dump tick emits a header and then N step
// and N code records (N = samples_per_test+1, capped at MAX_SLOTS); each record
// needs a read of the slot RAM and a load of the output register.
// The output register lets the next word be accepted while a result still
// waits; if m_tready stays low the sequencer holds at its next result and
// s_tready stays low. Reset clears the sequence to idle, the counters and the
// output valid, and loads the register defaults; slot RAM contents are not
// cleared and are valid only once written by a test.
module stepper_touch_probe_sequencer_top import stps_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,  // button_level, probe_code[9:0], zero fill
  output logic              m_tvalid,
  input  logic              m_tready,
  // move_steps[15:0], fast_speed, settle_ms[7:0], record_index[3:0],
  // record_value[15:0], zero fill
  output logic [47:0]       m_tdata,
  output logic [1:0]        m_tuser,  // item_kind
  output logic              m_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;

  stps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stps_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

/* hw/rtl/stps_ram.sv */
module stps_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/stps_dp.sv */
module stps_dp import stps_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  input  logic [15:0]       s_tdata,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [47:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat
);

  localparam int SW    = $clog2(MAX_SLOTS);
  localparam int CMP_W = (SW + 1 > 5) ? SW + 1 : 5;
  localparam int RAM_W = 26;

  logic [9:0]  code_low, code_high, chunk;
  logic [15:0] offset;
  logic [3:0]  samples, tests_limit;

  logic        button_q;
  logic [9:0]  code_q;

  logic [3:0]  sample_count, test_count, dump_idx, dump_last;
  logic [14:0] home_steps, backoff_steps, creep_steps;

  logic        cfg_wr;
  logic [15:0] backoff_sum;
  logic [14:0] home_inc, creep_inc, backoff_add;
  logic signed [15:0] back;
  logic [17:0] pos_sum;
  logic [15:0] pos_sat;
  logic [SW-1:0] wslot;
  logic [RAM_W-1:0] rdata;

  logic [1:0]  o_kind;
  logic [15:0] o_steps, o_value;
  logic        o_fast, o_last;
  logic [7:0]  o_settle;
  logic [3:0]  o_idx;

  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_low    <= 10'd20;
      code_high   <= 10'd20;
      chunk       <= 10'd100;
      offset      <= 16'd1250;
      samples     <= 4'd10;
      tests_limit <= 4'd9;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_CODE_LOW:  code_low    <= pwdata[9:0];
        REG_CODE_HIGH: code_high   <= pwdata[9:0];
        REG_CHUNK:     chunk       <= pwdata[9:0];
        REG_OFFSET:    offset      <= pwdata[15:0];
        REG_SAMPLES:   samples     <= pwdata[3:0];
        REG_TESTS:     tests_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_CODE_LOW:  prdata = {22'd0, code_low};
      REG_CODE_HIGH: prdata = {22'd0, code_high};
      REG_CHUNK:     prdata = {22'd0, chunk};
      REG_OFFSET:    prdata = {16'd0, offset};
      REG_SAMPLES:   prdata = {28'd0, samples};
      REG_TESTS:     prdata = {28'd0, tests_limit};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      button_q <= s_tdata[0];
      code_q   <= s_tdata[10:1];
    end
  end

  // saturating step counters
  assign home_inc    = (home_steps == CNT_MAX) ? CNT_MAX : home_steps + 15'd1;
  assign creep_inc   = (creep_steps == CNT_MAX) ? CNT_MAX : creep_steps + 15'd1;
  assign backoff_sum = {1'b0, backoff_steps} + {6'd0, chunk};
  assign backoff_add = backoff_sum[15] ? CNT_MAX : backoff_sum[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      test_count    <= '0;
      home_steps    <= '0;
      backoff_steps <= '0;
      creep_steps   <= '0;
      dump_idx      <= '0;
    end else begin
      if (cmd.clr_all || cmd.clr_home) begin
        home_steps <= '0;
      end else if (cmd.inc_home) begin
        home_steps <= home_inc;
      end
      if (cmd.clr_all || cmd.clr_steps) begin
        backoff_steps <= '0;
        creep_steps   <= '0;
      end else begin
        if (cmd.add_backoff) begin
          backoff_steps <= backoff_add;
        end
        if (cmd.inc_creep) begin
          creep_steps <= creep_inc;
        end
      end
      if (cmd.clr_all || cmd.clr_sample) begin
        sample_count <= '0;
      end else if (cmd.inc_sample) begin
        sample_count <= sample_count + 4'd1;
      end
      if (cmd.clr_all) begin
        test_count <= '0;
      end else if (cmd.inc_test) begin
        test_count <= test_count + 4'd1;
      end
      if (cmd.idx_clr) begin
        dump_idx <= '0;
      end else if (cmd.idx_inc) begin
        dump_idx <= dump_idx + 4'd1;
      end
    end
  end

  // recorded position, clamped to 0..65535
  assign back    = $signed({1'b0, backoff_steps}) - $signed({1'b0, creep_steps});
  assign pos_sum = {{2{back[15]}}, back} + {3'd0, home_steps} + {2'd0, offset};
  assign pos_sat = pos_sum[17] ? 16'd0 : (pos_sum[16] ? 16'hffff : pos_sum[15:0]);

  assign wslot = (CMP_W'(sample_count) >= CMP_W'(MAX_SLOTS)) ? SW'(MAX_SLOTS - 1)
                                                             : SW'(sample_count);
  assign dump_last = (CMP_W'(samples) >= CMP_W'(MAX_SLOTS)) ? 4'(MAX_SLOTS - 1) : samples;

  stps_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wslot),
    .wdata ({code_q, pos_sat}),
    .raddr (SW'(dump_idx)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_kind   <= KIND_MOVE;
      o_steps  <= '0;
      o_fast   <= 1'b0;
      o_settle <= '0;
      o_idx    <= '0;
      o_value  <= '0;
      o_last   <= cmd.last;
      if (cmd.header) begin
        o_kind  <= KIND_HEADER;
        o_value <= 16'(test_count) + 16'd1;
      end else begin
        unique case (cmd.sel)
          EM_SEEK: begin
            o_steps  <= 16'hffff;
            o_settle <= SETTLE_SEEK;
          end
          EM_BACKOFF: begin
            o_steps  <= 16'd0 - {6'd0, chunk};
            o_settle <= SETTLE_LONG;
          end
          EM_SAMPLE_BACK: begin
            o_steps  <= back;
            o_settle <= SETTLE_LONG;
          end
          EM_FINAL_BACK: begin
            o_steps  <= back;
            o_settle <= SETTLE_FINAL;
          end
          EM_CREEP: begin
            o_steps  <= 16'd1;
            o_fast   <= 1'b1;
            o_settle <= SETTLE_CREEP;
          end
          EM_HOME: begin
            o_steps  <= {1'b0, home_steps};
            o_fast   <= 1'b1;
            o_settle <= SETTLE_LONG;
          end
          EM_POS: begin
            o_kind  <= KIND_STEP;
            o_idx   <= dump_idx;
            o_value <= rdata[15:0];
          end
          EM_CODE_REC: begin
            o_kind  <= KIND_CODE;
            o_idx   <= dump_idx;
            o_value <= {6'd0, rdata[25:16]};
          end
        endcase
      end
    end
  end

  assign m_tdata = {3'd0, o_value, o_idx, o_settle, o_fast, o_steps};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

  assign stat.contact      = (code_q >= code_low) && (code_q <= code_high);
  assign stat.button       = button_q;
  assign stat.final_sample = sample_count >= samples;
  assign stat.idx_last     = dump_idx == dump_last;
  assign stat.test_done    = test_count >= tests_limit;
  assign stat.out_free     = ~m_tvalid | m_tready;

endmodule

/* hw/rtl/stps_ctrl.sv */
module stps_ctrl import stps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IN      = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_HOME    = 3'd2;
  localparam logic [2:0] S_POS_RD  = 3'd3;
  localparam logic [2:0] S_POS_EM  = 3'd4;
  localparam logic [2:0] S_CODE_RD = 3'd5;
  localparam logic [2:0] S_CODE_EM = 3'd6;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WAIT    = 3'd1;
  localparam logic [2:0] MODE_SEEK    = 3'd2;
  localparam logic [2:0] MODE_BACKOFF = 3'd3;
  localparam logic [2:0] MODE_FWD     = 3'd4;
  localparam logic [2:0] MODE_DUMP    = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] mode, mode_next;

  assign s_tready = (state == S_IN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      mode  <= MODE_IDLE;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.sel    = EM_SEEK;
    state_next = state;
    mode_next  = mode;
    unique case (state)
      S_IN: begin
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (mode)
          MODE_IDLE: begin
            mode_next  = MODE_WAIT;
            state_next = S_IN;
          end
          MODE_WAIT: begin
            if (!stat.button) begin
              mode_next = MODE_SEEK;
            end
            state_next = S_IN;
          end
          MODE_SEEK: begin
            if (stat.out_free) begin
              cmd.emit     = 1'b1;
              cmd.sel      = EM_SEEK;
              cmd.last     = 1'b1;
              cmd.inc_home = 1'b1;
              if (stat.contact) begin
                mode_next = MODE_BACKOFF;
              end
              state_next = S_IN;
            end
          end
          MODE_BACKOFF: begin
            if (stat.out_free) begin
              cmd.emit        = 1'b1;
              cmd.sel         = EM_BACKOFF;
              cmd.last        = 1'b1;
              cmd.add_backoff = 1'b1;
              if (!stat.contact) begin
                mode_next = MODE_FWD;
              end
              state_next = S_IN;
            end
          end
          MODE_FWD: begin
            if (stat.out_free) begin
              cmd.emit = 1'b1;
              priority if (stat.final_sample) begin
                cmd.sel    = EM_FINAL_BACK;
                cmd.store  = 1'b1;
                state_next = S_HOME;
              end else if (stat.contact) begin
                cmd.sel        = EM_SAMPLE_BACK;
                cmd.last       = 1'b1;
                cmd.store      = 1'b1;
                cmd.inc_sample = 1'b1;
                cmd.clr_steps  = 1'b1;
                mode_next      = MODE_BACKOFF;
                state_next     = S_IN;
              end else begin
                cmd.sel       = EM_CREEP;
                cmd.last      = 1'b1;
                cmd.inc_creep = 1'b1;
                state_next    = S_IN;
              end
            end
          end
          MODE_DUMP: begin
            if (stat.out_free) begin
              cmd.emit    = 1'b1;
              cmd.header  = 1'b1;
              cmd.idx_clr = 1'b1;
              state_next  = S_POS_RD;
            end
          end
          default: begin
            cmd.clr_all = 1'b1;
            mode_next   = MODE_IDLE;
            state_next  = S_IN;
          end
        endcase
      end
      S_HOME: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.sel        = EM_HOME;
          cmd.last       = 1'b1;
          cmd.clr_sample = 1'b1;
          cmd.clr_home   = 1'b1;
          cmd.clr_steps  = 1'b1;
          mode_next      = MODE_DUMP;
          state_next     = S_IN;
        end
      end
      S_POS_RD: begin
        state_next = S_POS_EM;
      end
      S_POS_EM: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_POS;
          if (stat.idx_last) begin
            cmd.idx_clr = 1'b1;
          end else begin
            cmd.idx_inc = 1'b1;
          end
          state_next = S_CODE_RD;
          if (!stat.idx_last) begin
            state_next = S_POS_RD;
          end
        end
      end
      S_CODE_RD: begin
        state_next = S_CODE_EM;
      end
      S_CODE_EM: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_CODE_REC;
          if (stat.idx_last) begin
            cmd.last   = 1'b1;
            state_next = S_IN;
            if (stat.test_done) begin
              cmd.clr_all = 1'b1;
              mode_next   = MODE_IDLE;
            end else begin
              cmd.inc_test = 1'b1;
              mode_next    = MODE_SEEK;
            end
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_CODE_RD;
          end
        end
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result loaded while output register occupied");

  a_store_with_move: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (cmd.emit && (cmd.sel == EM_SAMPLE_BACK || cmd.sel == EM_FINAL_BACK)))
    else $error("sample stored without its move");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> s_tready)
    else $error("final result of a tick did not release the input");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_in |=> !s_tready)
    else $error("second word taken before the first was handled");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import stps_pkg::*;

  localparam int SLOTS = 16;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_WAIT,
    SEQ_SEEK,
    SEQ_BACKOFF,
    SEQ_FORWARD,
    SEQ_DUMP
  } seq_mode_t;

  typedef struct packed {
    logic       button;
    logic [9:0] code;
  } probe_tick_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] steps;
    logic        fast;
    logic [7:0]  settle;
    logic [3:0]  slot;
    logic [15:0] value;
    logic        last;
  } probe_result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;  // button_level, probe_code[9:0], zero fill
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // move_steps[15:0], fast_speed, settle_ms[7:0], record_index[3:0],
  // record_value[15:0], zero fill
  logic [47:0]       m_tdata;
  logic [1:0]        m_tuser;  // item_kind
  logic              m_tlast;

  stepper_touch_probe_sequencer_top #(.MAX_SLOTS(SLOTS)) i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // register copy
  logic [9:0]  cfg_lo = 10'd20;
  logic [9:0]  cfg_hi = 10'd20;
  logic [9:0]  cfg_chunk = 10'd100;
  logic [15:0] cfg_offset = 16'd1250;
  logic [3:0]  cfg_spt = 4'd10;
  logic [3:0]  cfg_tl = 4'd9;

  // sequencer state
  seq_mode_t   seq_mode = SEQ_IDLE;
  logic [3:0]  sample_cnt = '0;
  logic [3:0]  test_cnt = '0;
  logic [14:0] home_steps = '0;
  logic [14:0] backoff_steps = '0;
  logic [14:0] creep_steps = '0;
  logic [15:0] pos_slot [SLOTS];
  logic [9:0]  code_slot [SLOTS];

  probe_tick_t   tick_words [$];
  probe_result_t probe_outputs [$];
  probe_tick_t   next_tick;
  probe_result_t seen_word;

  int  ticks_sent = 0;
  int  ticks_taken = 0;
  int  words_checked = 0;
  int  settings_applied = 0;
  int  mismatches = 0;
  int  send_gap = 0;
  int  hold_cycles = 0;
  bit  calm = 1'b0;

  function automatic logic [14:0] sat_count(logic [14:0] a, int b);
    int s;
    s = int'(a) + b;
    return (s > int'(CNT_MAX)) ? CNT_MAX : 15'(s);
  endfunction

  function automatic void push_result(logic [1:0] kind, int steps, logic fast,
                                      logic [7:0] settle, logic [3:0] slot,
                                      logic [15:0] value);
    probe_result_t r;
    r.kind = kind;
    r.steps = 16'(steps);
    r.fast = fast;
    r.settle = settle;
    r.slot = slot;
    r.value = value;
    r.last = 1'b0;
    probe_outputs.push_back(r);
  endfunction

  function automatic void record_sample(logic [9:0] code);
    int p;
    int s;
    p = int'(backoff_steps) - int'(creep_steps) + int'(home_steps) + int'(cfg_offset);
    s = (int'(sample_cnt) >= SLOTS) ? SLOTS - 1 : int'(sample_cnt);
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    pos_slot[s] = 16'(p);
    code_slot[s] = code;
  endfunction

  function automatic void step_sequencer(logic button, logic [9:0] code);
    logic          touching;
    int            back;
    int            n;
    int            cnt;
    int            i;
    probe_result_t r;
    touching = (code >= cfg_lo) && (code <= cfg_hi);
    back = int'(backoff_steps) - int'(creep_steps);
    n = probe_outputs.size();
    case (seq_mode)
      SEQ_WAIT: begin
        if (!button) seq_mode = SEQ_SEEK;
      end
      SEQ_SEEK: begin
        if (touching) seq_mode = SEQ_BACKOFF;
        home_steps = sat_count(home_steps, 1);
        push_result(KIND_MOVE, -1, 1'b0, SETTLE_SEEK, '0, '0);
      end
      SEQ_BACKOFF: begin
        backoff_steps = sat_count(backoff_steps, int'(cfg_chunk));
        push_result(KIND_MOVE, -int'(cfg_chunk), 1'b0, SETTLE_LONG, '0, '0);
        if (!touching) seq_mode = SEQ_FORWARD;
      end
      SEQ_FORWARD: begin
        if (sample_cnt >= cfg_spt) begin
          record_sample(code);
          push_result(KIND_MOVE, back, 1'b0, SETTLE_FINAL, '0, '0);
          push_result(KIND_MOVE, int'(home_steps), 1'b1, SETTLE_LONG, '0, '0);
          sample_cnt = '0;
          home_steps = '0;
          backoff_steps = '0;
          creep_steps = '0;
          seq_mode = SEQ_DUMP;
        end else if (touching) begin
          record_sample(code);
          sample_cnt = sample_cnt + 4'd1;
          push_result(KIND_MOVE, back, 1'b0, SETTLE_LONG, '0, '0);
          backoff_steps = '0;
          creep_steps = '0;
          seq_mode = SEQ_BACKOFF;
        end else begin
          creep_steps = sat_count(creep_steps, 1);
          push_result(KIND_MOVE, 1, 1'b1, SETTLE_CREEP, '0, '0);
        end
      end
      SEQ_DUMP: begin
        cnt = int'(cfg_spt) + 1;
        if (cnt > SLOTS) cnt = SLOTS;
        push_result(KIND_HEADER, 0, 1'b0, '0, '0, 16'(int'(test_cnt) + 1));
        for (i = 0; i < cnt; i++) push_result(KIND_STEP, 0, 1'b0, '0, 4'(i), pos_slot[i]);
        for (i = 0; i < cnt; i++)
          push_result(KIND_CODE, 0, 1'b0, '0, 4'(i), 16'(code_slot[i]));
        if (test_cnt >= cfg_tl) begin
          sample_cnt = '0;
          test_cnt = '0;
          home_steps = '0;
          backoff_steps = '0;
          creep_steps = '0;
          seq_mode = SEQ_IDLE;
        end else begin
          test_cnt = test_cnt + 4'd1;
          seq_mode = SEQ_SEEK;
        end
      end
      default: begin
        seq_mode = SEQ_WAIT;
      end
    endcase
    if (probe_outputs.size() > n) begin
      r = probe_outputs.pop_back();
      r.last = 1'b1;
      probe_outputs.push_back(r);
    end
  endfunction

  function automatic int pause_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // input word driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (tick_words.size() > 0) begin
        next_tick = tick_words.pop_front();
        s_tdata <= {5'b0, next_tick.code, next_tick.button};
        s_tvalid <= 1'b1;
        send_gap = (calm || $urandom_range(0, 99) < 55) ? 0 : pause_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      step_sequencer(s_tdata[0], s_tdata[10:1]);
      ticks_taken++;
    end
  end

  // output word monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_checked++;
        if (probe_outputs.size() == 0) begin
          $error("unexpected output word: kind %0d data %h", m_tuser, m_tdata);
          mismatches++;
        end else begin
          seen_word = probe_outputs.pop_front();
          check_field("item_kind", seen_word.kind, m_tuser);
          check_field("move_steps", seen_word.steps, m_tdata[15:0]);
          check_field("fast_speed", seen_word.fast, m_tdata[16]);
          check_field("settle_ms", seen_word.settle, m_tdata[24:17]);
          check_field("record_index", seen_word.slot, m_tdata[28:25]);
          check_field("record_value", seen_word.value, m_tdata[44:29]);
          check_field("last", seen_word.last, m_tlast);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) hold_cycles = pause_len();
      end
    end
  end

  task automatic push_tick(input logic button, input int code);
    probe_tick_t t;
    t.button = button;
    t.code = 10'(code);
    tick_words.push_back(t);
    ticks_sent++;
  endtask

  task automatic drain();
    while (ticks_taken != ticks_sent) @(negedge clk);
  endtask

  task automatic wait_quiet();
    while (ticks_taken != ticks_sent || probe_outputs.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] reg_idx, input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_config(input int lo, input int hi, input int chunk, input int offset,
                              input int spt, input int tl);
    wait_quiet();
    apb_write(REG_CODE_LOW, lo);
    apb_write(REG_CODE_HIGH, hi);
    apb_write(REG_CHUNK, chunk);
    apb_write(REG_OFFSET, offset);
    apb_write(REG_SAMPLES, spt);
    apb_write(REG_TESTS, tl);
    cfg_lo = 10'(lo);
    cfg_hi = 10'(hi);
    cfg_chunk = 10'(chunk);
    cfg_offset = 16'(offset);
    cfg_spt = 4'(spt);
    cfg_tl = 4'(tl);
    settings_applied++;
  endtask

  function automatic int window_code(bit touching);
    if (touching) return (cfg_lo <= cfg_hi) ? $urandom_range(cfg_lo, cfg_hi)
                                            : $urandom_range(0, 1023);
    if (cfg_lo > cfg_hi || (cfg_lo == 0 && cfg_hi == 1023)) return $urandom_range(0, 1023);
    if (cfg_lo == 0) return $urandom_range(int'(cfg_hi) + 1, 1023);
    if (cfg_hi == 1023) return $urandom_range(0, int'(cfg_lo) - 1);
    return $urandom_range(0, 1) ? $urandom_range(0, int'(cfg_lo) - 1)
                                : $urandom_range(int'(cfg_hi) + 1, 1023);
  endfunction

  // a well-formed run of ticks that moves the sequencer on from its current mode
  task automatic push_segment(input int long_pct);
    int n;
    case (seq_mode)
      SEQ_WAIT: begin
        repeat ($urandom_range(0, 2)) push_tick(1'b1, $urandom_range(0, 1023));
        push_tick(1'b0, $urandom_range(0, 1023));
      end
      SEQ_SEEK: begin
        repeat ($urandom_range(0, 1)) push_tick(1'($urandom_range(0, 1)), window_code(1'b0));
        push_tick(1'($urandom_range(0, 1)), window_code(1'b1));
      end
      SEQ_BACKOFF: begin
        n = ($urandom_range(0, 99) < long_pct) ? $urandom_range(33, 36) : $urandom_range(0, 1);
        repeat (n) push_tick(1'($urandom_range(0, 1)), window_code(1'b1));
        push_tick(1'($urandom_range(0, 1)), window_code(1'b0));
      end
      SEQ_FORWARD: begin
        if (sample_cnt < cfg_spt) begin
          repeat ($urandom_range(0, 1))
            push_tick(1'($urandom_range(0, 1)), window_code(1'b0));
          push_tick(1'($urandom_range(0, 1)), window_code(1'b1));
        end else begin
          push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 1023));
        end
      end
      default: begin
        push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 1023));
      end
    endcase
  endtask

  // bring the sequencer to the start of a test, or back to idle
  task automatic finish_run(input bit whole);
    while (!(seq_mode == SEQ_IDLE || seq_mode == SEQ_WAIT ||
             (!whole && seq_mode == SEQ_SEEK))) begin
      push_segment(0);
      drain();
    end
  endtask

  task automatic run_phase(input int spt, input int tl, input int chunk, input int budget,
                           input int long_pct, input bit whole);
    int  lo;
    int  hi;
    int  offset;
    int  counted;
    int  sent_at_start;
    bit  busy;
    case ($urandom_range(0, 4))
      0: begin
        lo = 0;
        hi = $urandom_range(0, 6);
      end
      1: begin
        hi = 1023;
        lo = 1023 - $urandom_range(0, 6);
      end
      default: begin
        lo = $urandom_range(1, 1010);
        hi = lo + $urandom_range(0, 8);
      end
    endcase
    case ($urandom_range(0, 3))
      0: offset = 0;
      1: offset = 65535;
      default: offset = $urandom_range(0, 65535);
    endcase
    if (chunk < 0) begin
      case ($urandom_range(0, 3))
        0: chunk = 1;
        1: chunk = 1023;
        default: chunk = $urandom_range(1, 1023);
      endcase
    end
    if (spt < 0) spt = $urandom_range(0, 3);
    if (tl < 0) tl = $urandom_range(0, 2);
    apply_config(lo, hi, chunk, offset, spt, tl);
    calm = ($urandom_range(0, 3) == 0);
    counted = 0;
    while (counted < budget) begin
      busy = (seq_mode != SEQ_IDLE && seq_mode != SEQ_WAIT);
      sent_at_start = ticks_sent;
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(1, 3))
          push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 1023));
      else
        push_segment(long_pct);
      if (busy) counted += ticks_sent - sent_at_start;
      drain();
    end
    finish_run(whole);
  endtask

  initial begin : stimulus
    int w;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // contact at code 0 only, no samples before the final one, saturated position
    apply_config(0, 0, 1023, 65535, 0, 0);
    push_tick(1'b0, 1023);
    push_tick(1'b1, 0);
    push_tick(1'b0, 1023);
    push_tick(1'b1, 1023);
    push_tick(1'b0, 0);
    push_tick(1'b1, 0);
    push_tick(1'b0, 512);
    push_tick(1'b1, 341);
    push_tick(1'b0, 682);

    // creeping past the back-off drives the position below zero
    apply_config(5, 5, 1, 0, 2, 0);
    push_tick(1'b1, 5);
    push_tick(1'b0, 5);
    push_tick(1'b0, 5);
    push_tick(1'b0, 6);
    push_tick(1'b0, 4);
    push_tick(1'b0, 6);
    push_tick(1'b0, 1023);
    push_tick(1'b0, 5);
    drain();
    finish_run(1'b1);

    // empty window, then a window that always touches
    apply_config(600, 500, 1, 0, 2, 1);
    push_tick(1'b1, 0);
    push_tick(1'b0, 0);
    push_tick(1'b1, 500);
    push_tick(1'b0, 600);
    push_tick(1'b1, 550);
    apply_config(0, 1023, 7, 300, 2, 1);
    push_tick(1'b0, 0);
    push_tick(1'b1, 1023);
    push_tick(1'b0, 77);
    apply_config(20, 20, 3, 1250, 2, 0);
    drain();
    finish_run(1'b1);

    run_phase(-1, -1, -1, 8, 5, 1'b0);
    run_phase(0, 0, 1023, 6, 100, 1'b0);  // back-off counter saturates
    run_phase(15, 0, -1, 4, 0, 1'b1);     // full-length dump
    run_phase(-1, -1, -1, 8, 5, 1'b0);
    finish_run(1'b1);

    for (w = 0; w < 200000; w++) begin
      if (ticks_taken == ticks_sent && probe_outputs.size() == 0) break;
      @(negedge clk);
    end
    repeat (100) @(negedge clk);
    if (probe_outputs.size() != 0) begin
      $error("%0d expected output words never arrived", probe_outputs.size());
      mismatches++;
    end
    $display("Sent %0d probe ticks, checked %0d output words over %0d register settings.",
             ticks_taken, words_checked, settings_applied);
    $display("Covered empty and full windows, zero and 15 samples and counter saturation.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $error("run did not complete in time");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/stps_pkg.sv
hw/rtl/stps_ram.sv
hw/rtl/stps_dp.sv
hw/rtl/stps_ctrl.sv
hw/rtl/stepper_touch_probe_sequencer_top.sv
verif/testbench.sv
